/* sv/emrt_pkg.sv */
// ----------------------------------------------------------------------------
// emrt_pkg
// Shared types and constants for the exact-match route table.
// ----------------------------------------------------------------------------
package emrt_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int IFACE_BITS_DEF = 16;

  localparam int ACTION_W     = 2;
  localparam int ADDR_W       = 64;
  localparam int PORT_IFACE_W = 16;
  localparam int STATUS_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [PORT_IFACE_W-1:0] iface;
  } res_t;

  // stored interface width: the port carries at most PORT_IFACE_W bits
  function automatic int iface_store_w(int iface_bits);
    return (iface_bits < PORT_IFACE_W) ? iface_bits : PORT_IFACE_W;
  endfunction

endpackage

/* sv/emrt_ifs.sv */
// ----------------------------------------------------------------------------
// emrt_ifs
// Request and response channels of the route table (valid/ready).
// ----------------------------------------------------------------------------
interface emrt_req_if import emrt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic [ADDR_W-1:0]       addr;
  logic [PORT_IFACE_W-1:0] iface_in;

  modport source (output valid, action, addr, iface_in, input ready);
  modport sink   (input valid, action, addr, iface_in, output ready);
endinterface

interface emrt_rsp_if import emrt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [PORT_IFACE_W-1:0] iface_out;

  modport source (output valid, status, iface_out, input ready);
  modport sink   (input valid, status, iface_out, output ready);
endinterface

/* sv/emrt_ram.sv */
// ----------------------------------------------------------------------------
// emrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module emrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/emrt_seq.sv */
// ----------------------------------------------------------------------------
// emrt_seq
// Sequencer: list walk with one shared key comparator, add, delete, clear,
// and the link-memory rebuild sweep.
// ----------------------------------------------------------------------------
module emrt_seq import emrt_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int IFACE_BITS = IFACE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  emrt_req_if.sink                           req,
  output logic                               res_valid,
  input  logic                               res_ready,
  output res_t                               res,
  // data stores (key and interface share address and write enable)
  output logic                               data_we,
  output logic [$clog2(ENTRIES)-1:0]         data_wa,
  output logic [ADDR_W-1:0]                  key_wd,
  output logic [iface_store_w(IFACE_BITS)-1:0] iface_wd,
  input  logic [ADDR_W-1:0]                  key_rdata,
  input  logic [iface_store_w(IFACE_BITS)-1:0] iface_rdata,
  // link store
  output logic                               link_we,
  output logic [$clog2(ENTRIES)-1:0]         link_wa,
  output logic [$clog2(ENTRIES+1)-1:0]       link_wd,
  input  logic [$clog2(ENTRIES+1)-1:0]       link_rdata,
  // shared read address
  output logic [$clog2(ENTRIES)-1:0]         rd_addr
);

  localparam int AW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int SW = iface_store_w(IFACE_BITS);
  localparam logic [LW-1:0] NONE     = LW'(ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_ADD,
    S_RD,
    S_CMP,
    S_UNLINK,
    S_FIN
  } state_t;

  state_t            state;
  logic [AW-1:0]     idx;
  logic              sweep_rsp;
  logic [LW-1:0]     list_head;
  logic [LW-1:0]     free_head;
  logic [LW-1:0]     cur;
  logic [LW-1:0]     prev;
  logic [LW-1:0]     steps;
  action_t           act;
  logic [ADDR_W-1:0] key;
  logic [SW-1:0]     iface_r;
  logic              hit;

  assign hit       = (key_rdata == key);
  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign rd_addr   = (state == S_IDLE) ? free_head[AW-1:0] : cur[AW-1:0];

  assign data_we  = (state == S_ADD);
  assign data_wa  = free_head[AW-1:0];
  assign key_wd   = key;
  assign iface_wd = iface_r;

  always_comb begin
    link_we = 1'b0;
    link_wa = idx;
    link_wd = LW'(idx) + LW'(1);
    unique case (state)
      S_SWEEP: begin
        link_we = 1'b1;
      end
      S_ADD: begin
        link_we = 1'b1;
        link_wa = free_head[AW-1:0];
        link_wd = list_head;
      end
      S_CMP: begin
        if (hit && act == ACT_DELETE && prev < NONE) begin
          link_we = 1'b1;
          link_wa = prev[AW-1:0];
          link_wd = link_rdata;
        end
      end
      S_UNLINK: begin
        link_we = 1'b1;
        link_wa = cur[AW-1:0];
        link_wd = free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      idx       <= '0;
      sweep_rsp <= 1'b0;
      list_head <= NONE;
      free_head <= '0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          if (idx == LAST_IDX) begin
            idx       <= '0;
            sweep_rsp <= 1'b0;
            res       <= '{status: ST_OK, iface: '0};
            state     <= sweep_rsp ? S_FIN : S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            act     <= action_t'(req.action);
            key     <= req.addr;
            iface_r <= req.iface_in[SW-1:0];
            cur     <= list_head;
            prev    <= NONE;
            steps   <= '0;
            unique case (action_t'(req.action))
              ACT_LOOKUP, ACT_DELETE: begin
                state <= S_RD;
              end
              ACT_ADD: begin
                if (free_head >= NONE) begin
                  res   <= '{status: ST_FULL, iface: '0};
                  state <= S_FIN;
                end else begin
                  state <= S_ADD;
                end
              end
              ACT_CLEAR: begin
                list_head <= NONE;
                free_head <= '0;
                idx       <= '0;
                sweep_rsp <= 1'b1;
                state     <= S_SWEEP;
              end
            endcase
          end
        end
        S_ADD: begin
          list_head <= free_head;
          free_head <= link_rdata;
          res       <= '{status: ST_OK, iface: '0};
          state     <= S_FIN;
        end
        S_RD: begin
          if (cur >= NONE || steps == NONE) begin
            res   <= '{status: ST_NOT_FOUND, iface: '0};
            state <= S_FIN;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            if (act == ACT_LOOKUP) begin
              res   <= '{status: ST_OK, iface: PORT_IFACE_W'(iface_rdata)};
              state <= S_FIN;
            end else begin
              if (prev >= NONE) begin
                list_head <= link_rdata;
              end
              state <= S_UNLINK;
            end
          end else begin
            prev  <= cur;
            cur   <= link_rdata;
            steps <= steps + LW'(1);
            state <= S_RD;
          end
        end
        S_UNLINK: begin
          free_head <= cur;
          res       <= '{status: ST_OK, iface: '0};
          state     <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/exact_match_route_table.sv */
// ----------------------------------------------------------------------------
// exact_match_route_table
// Exact-match address-to-interface table kept as a linked list, newest first.
//
//   channel  dir  beat fields                   handshake
//   req      in   action, addr, iface_in       valid/ready
//   rsp      out  status, iface_out            valid/ready
//
// Lookup and delete walk the list entry by entry through one key
// comparator fed by the key memory's registered read, visiting at most
// ENTRIES entries. After reset the link memory is rebuilt by a sweep;
// req is not ready during that sweep. One item at a time; a result
// waiting in the output register does not stop the next request from
// being accepted.
// ----------------------------------------------------------------------------
module exact_match_route_table import emrt_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int IFACE_BITS = IFACE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  emrt_req_if.sink   req,
  emrt_rsp_if.source rsp
);

  localparam int AW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int SW = iface_store_w(IFACE_BITS);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              data_we;
  logic [AW-1:0]     data_wa;
  logic [ADDR_W-1:0] key_wd;
  logic [SW-1:0]     iface_wd;
  logic [ADDR_W-1:0] key_rdata;
  logic [SW-1:0]     iface_rdata;
  logic              link_we;
  logic [AW-1:0]     link_wa;
  logic [LW-1:0]     link_wd;
  logic [LW-1:0]     link_rdata;
  logic [AW-1:0]     rd_addr;

  logic              out_valid;
  res_t              out_res;

  emrt_seq #(
    .ENTRIES    (ENTRIES),
    .IFACE_BITS (IFACE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .data_we     (data_we),
    .data_wa     (data_wa),
    .key_wd      (key_wd),
    .iface_wd    (iface_wd),
    .key_rdata   (key_rdata),
    .iface_rdata (iface_rdata),
    .link_we     (link_we),
    .link_wa     (link_wa),
    .link_wd     (link_wd),
    .link_rdata  (link_rdata),
    .rd_addr     (rd_addr)
  );

  emrt_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk     (clk),
    .we      (data_we),
    .wr_addr (data_wa),
    .wr_data (key_wd),
    .rd_addr (rd_addr),
    .rd_data (key_rdata)
  );

  emrt_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_iface_ram (
    .clk     (clk),
    .we      (data_we),
    .wr_addr (data_wa),
    .wr_data (iface_wd),
    .rd_addr (rd_addr),
    .rd_data (iface_rdata)
  );

  emrt_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
    .clk     (clk),
    .we      (link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd),
    .rd_addr (rd_addr),
    .rd_data (link_rdata)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_res.status;
  assign rsp.iface_out = out_res.iface;

endmodule
